// File: hw/rtl/usst_pkg.sv
// ============================================================================
// usst_pkg
// Shared types and constants for the unordered set store: transaction
// payloads, operation codes and status codes.
// ============================================================================
`default_nettype none

package usst_pkg;

    // Default number of entries the store can hold.
    localparam int CAPACITY_DEF = 64;

    // Width of the position and count fields in a result transaction.
    localparam int POS_W = 7;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    // Status codes returned with each result.
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_DUPLICATE  = 2'd1;
    localparam logic [1:0] ST_DEL_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] count_after;
        logic [1:0]       status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } t_seq_state;

endpackage

`default_nettype wire

// File: hw/rtl/usst_mem.sv
// ============================================================================
// usst_mem
// Element storage: one write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module usst_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [31:0]       o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [31:0]       i_wr_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hw/rtl/usst_seq.sv
// ============================================================================
// usst_seq
// Operation sequencer: runs the linear search over the element memory,
// appends on insert and compacts the memory on delete.
// ============================================================================
`default_nettype none

module usst_seq
    import usst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = 7,
    parameter int ADDR_W   = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire t_in_item          i_req,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_out_item              o_res,
    output logic                   o_rd_en,
    output logic      [ADDR_W-1:0] o_rd_addr,
    input  wire logic [31:0]       i_rd_data,
    output logic                   o_wr_en,
    output logic      [ADDR_W-1:0] o_wr_addr,
    output logic      [31:0]       o_wr_data
);

    t_seq_state r_state, n_state;

    logic [1:0]       r_kind, n_kind;
    logic [31:0]      r_value, n_value;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_found, n_found;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [1:0]       r_status, n_status;

    logic             w_match;
    logic             w_scan_more;
    logic             w_full;
    logic             w_search_end;
    logic             w_shift_end;
    logic [CNT_W-1:0] w_prev_idx;

    // A compare is pending for r_cmp_idx; the read data now holds that entry.
    assign w_match      = r_cmp_vld && (i_rd_data == r_value);
    assign w_scan_more  = (r_idx < r_count);
    assign w_full       = (r_count >= CNT_W'(CAPACITY));
    assign w_search_end = (r_state == S_SEARCH)
                          && (w_match || (!w_scan_more && !r_cmp_vld));
    assign w_shift_end  = (r_state == S_SHIFT) && !w_scan_more && !r_cmp_vld;
    assign w_prev_idx   = r_cmp_idx - CNT_W'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_search_end) begin
                    n_state = (r_kind == KIND_DELETE && w_match) ? S_SHIFT : S_RESP;
                end
            end
            S_SHIFT: begin
                if (w_shift_end) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_kind    = r_kind;
        n_value   = r_value;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_pos     = r_pos;
        n_status  = r_status;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[ADDR_W-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[ADDR_W-1:0];
        o_wr_data = r_value;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind    = i_req.kind;
                    n_value   = i_req.value;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                end
            end
            S_SEARCH: begin
                if (w_match) begin
                    n_found   = 1'b1;
                    n_pos     = r_cmp_idx;
                    n_cmp_vld = 1'b0;
                    n_idx     = r_cmp_idx + CNT_W'(1);
                    n_status  = (r_kind == KIND_INSERT) ? ST_DUPLICATE : ST_DONE;
                end else if (w_scan_more) begin
                    o_rd_en   = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    n_idx     = r_idx + CNT_W'(1);
                end else if (r_cmp_vld) begin
                    n_cmp_vld = 1'b0;
                end else begin
                    // Every stored entry was compared without a hit.
                    n_found  = 1'b0;
                    n_pos    = r_count;
                    n_status = ST_DONE;
                    if (r_kind == KIND_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_kind == KIND_DELETE) begin
                        n_status = ST_DEL_ABSENT;
                    end
                end
            end
            S_SHIFT: begin
                // Each entry read is written back one place lower.
                if (r_cmp_vld) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_prev_idx[ADDR_W-1:0];
                    o_wr_data = i_rd_data;
                end
                if (w_scan_more) begin
                    o_rd_en   = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    n_idx     = r_idx + CNT_W'(1);
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (w_shift_end) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_value   <= n_value;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_status  <= n_status;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_RESP);
    assign o_res.found       = r_found;
    assign o_res.position    = POS_W'(r_pos);
    assign o_res.count_after = POS_W'(r_count);
    assign o_res.status      = r_status;

endmodule

`default_nettype wire

// File: hw/rtl/unordered_set_store_core.sv
// ============================================================================
// unordered_set_store_core
// Set of distinct 32-bit values kept in insertion order, with lookup, insert
// and order-keeping delete over an element memory with one read port and one
// write port.
// ============================================================================
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// The search reads one entry per cycle and stops at the first hit or after
// the last of the N stored entries. A delete that hits then moves each later
// entry down with one read and one write per cycle. Reset clears the count
// and control state, not the memory.
// A result waits in the output register while the next transaction runs.
// ============================================================================
`default_nettype none

module unordered_set_store_core
    import usst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    // The count must reach CAPACITY itself; the address only CAPACITY - 1.
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              w_res_valid;
    logic              w_res_ready;
    t_out_item         w_res;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [31:0]       w_rd_data;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [31:0]       w_wr_data;

    logic      r_out_vld;
    t_out_item r_out_item;

    // The sequencer owns all element traffic; the memory only stores.
    usst_seq #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .ADDR_W   (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    usst_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Output register: it takes a new result whenever it is empty or its
    // current transaction completes in the same cycle.
    assign w_res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_out_vld <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    // A duplicate insert always reports the value as found.
    a_dup_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_DUPLICATE) |-> o_out_item.found)
        else $error("duplicate status without a hit");

    // Full and absent-delete results never report a hit.
    a_miss_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.status == ST_FULL)
                        || (o_out_item.status == ST_DEL_ABSENT))
        |-> !o_out_item.found)
        else $error("miss status with a hit");

    // A result offered by the sequencer holds until the output register takes it.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && !w_res_ready |=> w_res_valid && $stable(w_res))
        else $error("sequencer result changed while stalled");
`endif

endmodule

`default_nettype wire
